// File: rtl/fsdtm_pkg.sv
// ----------------------------------------------------------------------------
// fsdtm_pkg
// Shared constants, types and helpers for the float-switch tank monitor.
// ----------------------------------------------------------------------------
package fsdtm_pkg;

  localparam int unsigned NumTanks      = 4;
  localparam int unsigned NumSwitches   = 2 * NumTanks;
  localparam int unsigned StableSamples = 3;  // debounce window, 1..16

  localparam int unsigned EventW = 2 * NumSwitches;
  localparam int unsigned LevelW = 3;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutRawW  = EventW + NumSwitches + NumTanks * LevelW;
  localparam int unsigned OutDataW = ((OutRawW + 7) / 8) * 8;

  localparam logic [NumTanks-1:0] TankMaskReset = '1;

  typedef enum logic [LevelW-1:0] {
    LvlEmpty    = 3'd0,
    LvlMid      = 3'd1,
    LvlFull     = 3'd2,
    LvlUndef    = 3'd3,
    LvlInactive = 3'd4
  } level_e;

  typedef logic [NumSwitches-1:0] sample_t;

  // Level of one tank from its full switch (low) and empty switch (high)
  function automatic level_e tank_level(input logic active, input logic [1:0] sw);
    level_e lvl;
    lvl = LvlInactive;
    if (active) begin
      case (sw)
        2'b00:   lvl = LvlEmpty;
        2'b10:   lvl = LvlMid;
        2'b11:   lvl = LvlFull;
        2'b01:   lvl = LvlUndef;
        default: lvl = LvlUndef;
      endcase
    end
    return lvl;
  endfunction

endpackage

// File: rtl/float_switch_debounce_tank_monitor_top.sv
// ----------------------------------------------------------------------------
// float_switch_debounce_tank_monitor_top
// Debounced float-switch edge detector with per-tank sticky events and levels.
// ----------------------------------------------------------------------------
// One input word carries one tick of eight active-low float-switch pins plus a
// clear request; each input word yields exactly one output word. Tank k owns
// switch 2k (full switch) and switch 2k+1 (empty switch); disabled tanks read
// as off. A debounced change fires once, when the newest StableSamples samples
// agree and the sample before them differs, and reports on/off edges per
// switch. Full/empty marks collect in sticky flags that clear_events resets.
// The block is a two-stage pipeline (input register, then result register)
// and takes one word per clock while the output is not back-pressured.
// Sample history and sticky flags advance when a word moves from the input
// register to the result register. Write the tank mask only while the
// pipeline is empty.
// ----------------------------------------------------------------------------
module float_switch_debounce_tank_monitor_top
  import fsdtm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  // Config: active_tank_mask
  input  logic                cfg_we_i,
  input  logic [NumTanks-1:0] cfg_wdata_i,

  // Input stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [7:0] pin_levels, [8] clear_events, [15:9] zero
  input  logic [InDataW-1:0]  s_axis_tdata_i,

  // Output stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [15:0] switch_events, [23:16] latched_tank_events, [26:24] tank0_level,
  // [29:27] tank1_level, [32:30] tank2_level, [35:33] tank3_level, [39:36] zero
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  // --------------------------------------------------------------------------
  // Config register
  // --------------------------------------------------------------------------
  logic [NumTanks-1:0] tank_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tank_mask_q <= TankMaskReset;
    end else if (cfg_we_i) begin
      tank_mask_q <= cfg_wdata_i;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake
  // --------------------------------------------------------------------------
  logic in_valid_q, out_valid_q;
  logic out_ready, in_ready, in_fire, adv;

  assign out_ready       = !out_valid_q || m_axis_tready_i;
  assign adv             = in_valid_q && out_ready;   // stage 1 -> stage 2
  assign in_ready        = !in_valid_q || out_ready;
  assign in_fire         = s_axis_tvalid_i && in_ready;
  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready)  in_valid_q  <= s_axis_tvalid_i;
      if (out_ready) out_valid_q <= in_valid_q;
    end
  end

  // Input register (payload only)
  sample_t pins_q;
  logic    clear_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pins_q  <= s_axis_tdata_i[NumSwitches-1:0];
      clear_q <= s_axis_tdata_i[NumSwitches];
    end
  end

  // --------------------------------------------------------------------------
  // Sample, debounce and edge detection
  // --------------------------------------------------------------------------
  sample_t hist_q [StableSamples];   // [0] is oldest
  logic [NumSwitches-1:0] sticky_q;

  sample_t             sw_mask, sample, prev_sample, turned_on, turned_off;
  logic                fire;
  logic [EventW-1:0]   sw_events;
  logic [NumSwitches-1:0] tank_marks, sticky_d;
  level_e              levels [NumTanks];

  always_comb begin
    for (int k = 0; k < NumTanks; k++) begin
      sw_mask[2*k +: 2] = {2{tank_mask_q[k]}};
    end
    sample      = ~pins_q & sw_mask;       // pins are active low
    prev_sample = hist_q[0];

    // Newest StableSamples samples agree and differ from the one before
    fire = (prev_sample != sample);
    for (int i = 1; i < StableSamples; i++) begin
      if (hist_q[i] != sample) fire = 1'b0;
    end

    turned_on  = ~prev_sample & sample & sw_mask & {NumSwitches{fire}};
    turned_off = prev_sample & ~sample & sw_mask & {NumSwitches{fire}};
    for (int i = 0; i < NumSwitches; i++) begin
      sw_events[2*i]   = turned_on[i];
      sw_events[2*i+1] = turned_off[i];
    end

    // Full switch turned on -> full; empty switch turned off -> empty
    for (int k = 0; k < NumTanks; k++) begin
      tank_marks[2*k]   = turned_on[2*k];
      tank_marks[2*k+1] = turned_off[2*k+1];
      levels[k]         = tank_level(tank_mask_q[k], sample[2*k +: 2]);
    end

    sticky_d = (clear_q ? '0 : sticky_q) | tank_marks;
  end

  // State advances once per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < StableSamples; i++) hist_q[i] <= '0;
      sticky_q <= '0;
    end else if (adv) begin
      for (int i = 0; i + 1 < StableSamples; i++) hist_q[i] <= hist_q[i+1];
      hist_q[StableSamples-1] <= sample;
      sticky_q <= sticky_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic [OutRawW-1:0]  result;
  logic [OutDataW-1:0] out_data_q;

  always_comb begin
    result[EventW-1:0]                     = sw_events;
    result[EventW +: NumSwitches]          = sticky_d;
    for (int k = 0; k < NumTanks; k++) begin
      result[EventW + NumSwitches + k*LevelW +: LevelW] = levels[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {{(OutDataW-OutRawW){1'b0}}, result};
    end
  end

  assign m_axis_tdata_o = out_data_q;

endmodule
